// ===== rtl/ecpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_pkg: shared types and constants of the enhanced clock page replacer
// Command and status codes, cell control, and the sequencer states.
// ----------------------------------------------------------------------------
package ecpr_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int LIMIT_W        = 7;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOVICTIM = 2'd3;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_ACCESS,
    CELL_CLEAR,
    CELL_VICTIM
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     ins_en;
    logic     clr_use;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_APPLY,
    S_HOLD
  } state_t;

endpackage

// ===== rtl/ecpr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_if: item channels of the enhanced clock page replacer
// Request channel (command, page, dirty) and result channel (status, victim).
// ----------------------------------------------------------------------------
interface ecpr_in_if #(
  parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ecpr_pkg::CMD_W-1:0] cmd;
  logic [PAGE_BITS-1:0]       page;
  logic                       dirty;

  modport source (output valid, output cmd, output page, output dirty, input ready);
  modport sink   (input valid, input cmd, input page, input dirty, output ready);
endinterface

interface ecpr_out_if #(
  parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ecpr_pkg::STATUS_W-1:0] status;
  logic [PAGE_BITS-1:0]          victim_page;

  modport source (output valid, output status, output victim_page, input ready);
  modport sink   (input valid, input status, input victim_page, output ready);
endinterface

// ===== rtl/ecpr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_cell: one frame of the replacement table
// Holds a page tag with its valid, use and modified bits and applies the
// broadcast command; the valid bit of the left neighbor marks the append slot.
// ----------------------------------------------------------------------------
module ecpr_cell #(
  parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ecpr_pkg::cell_ctrl_t ctrl,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 dirty,
  input  logic                 prev_valid,
  input  logic                 sel,
  output logic                 valid,
  output logic                 use_o,
  output logic                 mod_o,
  output logic                 match,
  output logic [PAGE_BITS-1:0] tag
);
  import ecpr_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 use_r, use_nxt;
  logic                 mod_r, mod_nxt;
  logic [PAGE_BITS-1:0] tag_r, tag_nxt;
  logic                 tail;

  assign match = valid_r && (tag_r == page);
  assign tail  = prev_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    use_nxt   = use_r;
    mod_nxt   = mod_r;
    tag_nxt   = tag_r;
    case (ctrl.op)
      CELL_ACCESS: begin
        if (match) begin
          use_nxt = 1'b1;
          mod_nxt = dirty;
        end else if (ctrl.ins_en && tail) begin
          valid_nxt = 1'b1;
          tag_nxt   = page;
          use_nxt   = 1'b1;
          mod_nxt   = dirty;
        end
      end
      CELL_CLEAR: begin
        if (match) begin
          use_nxt = 1'b0;
          mod_nxt = 1'b0;
        end
      end
      CELL_VICTIM: begin
        // The victim takes a fresh use bit even when a sweep clears all others.
        if (sel) begin
          use_nxt = 1'b1;
          mod_nxt = 1'b0;
        end else if (ctrl.clr_use) begin
          use_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      use_r   <= 1'b0;
      mod_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      use_r   <= use_nxt;
      mod_r   <= mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign use_o = use_r;
  assign mod_o = mod_r;
  assign tag   = tag_r;

endmodule

// ===== rtl/ecpr_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_pick: circular first-candidate search
// Finds the lowest flagged frame at or above the start index, wrapping to the
// lowest flagged frame overall.
// ----------------------------------------------------------------------------
module ecpr_pick #(
  parameter int N = ecpr_pkg::MAX_FRAMES_DEF,
  localparam int IDX_W = $clog2(N)
) (
  input  logic [N-1:0]     flags,
  input  logic [IDX_W-1:0] start,
  output logic             any,
  output logic [IDX_W-1:0] idx
);
  logic [N-1:0] upper;
  logic [N-1:0] vec;
  logic [N-1:0] lowest;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      upper[i] = flags[i] && (IDX_W'(i) >= start);
    end
  end

  assign any    = |flags;
  assign vec    = (|upper) ? upper : flags;
  // Two's complement trick isolates the lowest set bit.
  assign lowest = vec & (~vec + N'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/enhanced_clock_page_replacer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer_unit: enhanced clock page replacer
// A row of frame cells with tag, use and modified bits, an append pointer,
// a clock hand and a sequencer for access, victim selection and clear.
//
//   Channel   Dir  Handshake            Payload
//   in_ch     in   valid/ready          cmd, page, dirty
//   out_ch    out  valid/ready          status, victim_page
//   cfg_*     in   cfg_we               cfg_wdata = frame_limit
//
// Access, clear and unknown commands go from idle to the exec state, which
// writes the result to the output register; the next item is accepted back
// in idle. Select victim also passes the apply state, set by the register
// between the circular search and the cell update. One item is in work at a
// time. Reset clears every cell's valid, use and modified bit.
// A result waiting on out_ch is held in the output register while the next
// item is accepted; a second finished result waits in a holding register and
// stops the input until the output register frees.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer_unit #(
  parameter int MAX_FRAMES = ecpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = ecpr_pkg::PAGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ecpr_in_if.sink                        in_ch,
  ecpr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ecpr_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import ecpr_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   lim_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     hand_r, hand_nxt;
  logic [IDX_W-1:0]     v_r, v_nxt;
  logic                 clr_r, clr_nxt;

  logic [CMD_W-1:0]     cmd_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 dirty_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [PAGE_BITS-1:0] out_victim_r, out_victim_nxt;
  logic [STATUS_W-1:0]  hold_status_r, hold_status_nxt;
  logic [PAGE_BITS-1:0] hold_victim_r, hold_victim_nxt;

  cell_ctrl_t           ctrl;
  logic [MAX_FRAMES-1:0] valid_w, use_w, mod_w, match_w, sel_w;
  logic [PAGE_BITS-1:0]  tag_w [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cand, f0, f1, f2, f3;
  logic [PAGE_BITS-1:0]  vpage;
  logic [IDX_W-1:0]      start;
  logic                  pick_any;
  logic [IDX_W-1:0]      pick_idx;

  logic in_fire, slot_free, hit, room, done;
  logic [STATUS_W-1:0]  res_status;
  logic [PAGE_BITS-1:0] res_victim;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.victim_page = out_victim_r;

  // ---- frame cells ----
  genvar g;
  generate
    for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
      assign sel_w[g] = (v_r == IDX_W'(g));
      ecpr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .page       (page_r),
        .dirty      (dirty_r),
        .prev_valid ((g == 0) ? 1'b1 : valid_w[(g == 0) ? 0 : g - 1]),
        .sel        (sel_w[g]),
        .valid      (valid_w[g]),
        .use_o      (use_w[g]),
        .mod_o      (mod_w[g]),
        .match      (match_w[g]),
        .tag        (tag_w[g])
      );
    end
  endgenerate

  assign hit  = |match_w;
  assign room = (CMP_W'(cnt_r) < CMP_W'(lim_r)) && (cnt_r < CNT_W'(MAX_FRAMES));

  // ---- victim search ----
  assign f0 = valid_w & ~use_w & ~mod_w;
  assign f1 = valid_w & ~use_w & mod_w;
  // After a use-bit sweep only the modified bit separates the classes.
  assign f2 = valid_w & mod_w;
  assign f3 = valid_w & ~mod_w;

  always_comb begin
    if (|f0) begin
      cand = f0;
    end else if (|f1) begin
      cand = f1;
    end else if (|f2) begin
      cand = f2;
    end else begin
      cand = f3;
    end
  end

  assign start = (hand_r < cnt_r) ? hand_r[IDX_W-1:0] : '0;

  ecpr_pick #(
    .N (MAX_FRAMES)
  ) u_pick (
    .flags (cand),
    .start (start),
    .any   (pick_any),
    .idx   (pick_idx)
  );

  always_comb begin
    vpage = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      vpage = vpage | (sel_w[i] ? tag_w[i] : '0);
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    hand_nxt        = hand_r;
    v_nxt           = v_r;
    clr_nxt         = clr_r;
    ctrl            = '{op: CELL_IDLE, ins_en: 1'b0, clr_use: 1'b0};
    done            = 1'b0;
    res_status      = ST_MISS;
    res_victim      = '0;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_victim_nxt  = out_victim_r;
    hold_status_nxt = hold_status_r;
    hold_victim_nxt = hold_victim_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_ACCESS: begin
            ctrl.op     = CELL_ACCESS;
            ctrl.ins_en = !hit && room;
            done        = 1'b1;
            if (hit) begin
              res_status = ST_HIT;
            end else if (room) begin
              res_status = ST_OK;
              cnt_nxt    = cnt_r + CNT_W'(1);
            end
          end
          CMD_VICTIM: begin
            if (cnt_r == '0) begin
              res_status = ST_NOVICTIM;
              done       = 1'b1;
            end else begin
              v_nxt     = pick_any ? pick_idx : '0;
              clr_nxt   = !(|f0) && !(|f1);
              state_nxt = S_APPLY;
            end
          end
          CMD_CLEAR: begin
            ctrl.op    = CELL_CLEAR;
            res_status = hit ? ST_OK : ST_MISS;
            done       = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_APPLY: begin
        ctrl.op      = CELL_VICTIM;
        ctrl.clr_use = clr_r;
        hand_nxt     = CNT_W'(v_r) + CNT_W'(1);
        res_status   = ST_OK;
        res_victim   = vpage;
        done         = 1'b1;
      end
      S_HOLD: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hold_status_r;
          out_victim_nxt = hold_victim_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_victim_nxt = res_victim;
        state_nxt      = S_IDLE;
      end else begin
        hold_status_nxt = res_status;
        hold_victim_nxt = res_victim;
        state_nxt       = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lim_r       <= LIMIT_RESET;
      cnt_r       <= '0;
      hand_r      <= '0;
      v_r         <= '0;
      clr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hand_r      <= hand_nxt;
      v_r         <= v_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_ch.cmd;
      page_r  <= in_ch.page;
      dirty_r <= in_ch.dirty;
    end
    out_status_r  <= out_status_nxt;
    out_victim_r  <= out_victim_nxt;
    hold_status_r <= hold_status_nxt;
    hold_victim_r <= hold_victim_nxt;
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAMES))
    else $error("entry count beyond the table size");

  a_unique_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(match_w))
    else $error("a page is held by more than one frame");

  a_victim_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> (CNT_W'(v_r) < cnt_r))
    else $error("victim index outside the filled frames");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r != S_IDLE))
    else $error("result raised without an item in work");

endmodule

// ===== bench/tb_enhanced_clock_page_replacer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_enhanced_clock_page_replacer_unit: bench for the enhanced clock replacer
// Drives access, select victim, clear and reserved commands through the
// request channel and checks every status and victim page against an
// in-bench model of the frame table, hand and frame limit. Frame limits of
// 0, 1, 4, 16, 64 and 127 are used, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_enhanced_clock_page_replacer_unit;
  import ecpr_pkg::*;

  localparam int MAX_FRAMES  = MAX_FRAMES_DEF;
  localparam int PAGE_BITS   = PAGE_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int POOL_SIZE   = 96;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = {PAGE_BITS{1'b1}};

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [PAGE_BITS-1:0] page;
    logic                 dirty;
  } page_req_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [PAGE_BITS-1:0] victim;
  } replace_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  ecpr_in_if  #(.PAGE_BITS(PAGE_BITS)) in_bus ();
  ecpr_out_if #(.PAGE_BITS(PAGE_BITS)) out_bus ();

  enhanced_clock_page_replacer_unit #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model of the frame table.
  logic [PAGE_BITS-1:0] frame_tag [MAX_FRAMES];
  logic                 frame_use [MAX_FRAMES];
  logic                 frame_mod [MAX_FRAMES];
  int                   frame_count;
  int                   clock_hand;
  logic [LIMIT_W-1:0]   frame_limit;

  page_req_t            pending_reqs [$];
  replace_result_t      due_results [$];
  page_req_t            next_req;
  logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];
  int                   pool_span;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   mismatches = 0;
  int                   quiet_cycles;

  // Circular search from the hand for an entry with the use bit clear and
  // the given modified bit; returns frame_count when there is none.
  function automatic int find_unused(input logic want_mod);
    int start;
    int k;
    int idx;
    start = (clock_hand < frame_count) ? clock_hand : 0;
    for (k = 0; k < frame_count; k++) begin
      idx = start + k;
      if (idx >= frame_count) idx -= frame_count;
      if (!frame_use[idx] && frame_mod[idx] == want_mod) return idx;
    end
    return frame_count;
  endfunction

  function automatic replace_result_t replace_step(input page_req_t req);
    replace_result_t r;
    int cap;
    int hit_idx;
    int v;
    int i;
    r.status = ST_MISS;
    r.victim = '0;
    cap = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    case (req.cmd)
      CMD_ACCESS: begin
        hit_idx = -1;
        for (i = 0; i < frame_count; i++)
          if (frame_tag[i] == req.page) hit_idx = i;
        if (hit_idx >= 0) begin
          frame_use[hit_idx] = 1'b1;
          frame_mod[hit_idx] = req.dirty;
          r.status = ST_HIT;
        end else if (frame_count < cap) begin
          frame_tag[frame_count] = req.page;
          frame_use[frame_count] = 1'b1;
          frame_mod[frame_count] = req.dirty;
          frame_count++;
          r.status = ST_OK;
        end
      end
      CMD_VICTIM: begin
        if (frame_count == 0) begin
          r.status = ST_NOVICTIM;
        end else begin
          v = find_unused(1'b0);
          if (v >= frame_count) v = find_unused(1'b1);
          if (v >= frame_count) begin
            // Every entry had its second chance: drop all use bits, then
            // prefer a modified page over a clean one.
            for (i = 0; i < frame_count; i++) frame_use[i] = 1'b0;
            v = find_unused(1'b1);
            if (v >= frame_count) v = find_unused(1'b0);
          end
          frame_use[v] = 1'b1;
          frame_mod[v] = 1'b0;
          clock_hand   = v + 1;
          r.victim     = frame_tag[v];
          r.status     = ST_OK;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < frame_count; i++) begin
          if (frame_tag[i] == req.page) begin
            frame_use[i] = 1'b0;
            frame_mod[i] = 1'b0;
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Request driver; also follows register writes and predicts each
  // accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.cmd   <= CMD_ACCESS;
      in_bus.page  <= '0;
      in_bus.dirty <= 1'b0;
      frame_count  = 0;
      clock_hand   = 0;
      frame_limit  = LIMIT_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_use[i] = 1'b0;
        frame_mod[i] = 1'b0;
        frame_tag[i] = '0;
      end
    end else begin
      if (cfg_we) frame_limit = cfg_wdata;
      if (in_bus.valid && in_bus.ready)
        due_results.push_back(replace_step('{in_bus.cmd, in_bus.page, in_bus.dirty}));
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.cmd   <= next_req.cmd;
          in_bus.page  <= next_req.page;
          in_bus.dirty <= next_req.dirty;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          report_fault($sformatf("result with no item waiting: status %0d victim %h",
                                 out_bus.status, out_bus.victim_page));
        end else begin
          if (out_bus.status !== due_results[0].status)
            report_fault($sformatf("status: expected %0d, got %0d",
                                   due_results[0].status, out_bus.status));
          if (out_bus.victim_page !== due_results[0].victim)
            report_fault($sformatf("victim_page: expected %h, got %h",
                                   due_results[0].victim, out_bus.victim_page));
          void'(due_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("enhanced_clock_page_replacer_unit verification failed");
      $finish;
    end
  end

  task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [PAGE_BITS-1:0] page,
                           input logic dirty);
    pending_reqs.push_back('{cmd, page, dirty});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_bus.valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly accesses and victim picks on a working set of pool pages, with
  // some fully random pages and reserved commands as noise.
  task automatic queue_random(input int count);
    int n;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [PAGE_BITS-1:0] page;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50)      cmd = CMD_ACCESS;
      else if (pick < 78) cmd = CMD_VICTIM;
      else if (pick < 94) cmd = CMD_CLEAR;
      else                cmd = CMD_RESERVED;
      if ($urandom_range(99) < 85) page = page_pool[$urandom_range(pool_span - 1)];
      else                         page = PAGE_BITS'($urandom);
      queue_req(cmd, page, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_idle_pct = 10;
    recv_idle_pct = 64;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_BITS'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table at the reset limit.
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    queue_req(CMD_CLEAR, 20'h12345, 1'b0);
    queue_req(CMD_RESERVED, PAGE_MAX, 1'b1);
    wait_drained();

    // A limit of zero admits nothing.
    write_limit(7'd0);
    queue_req(CMD_ACCESS, 20'h00000, 1'b0);
    queue_req(CMD_ACCESS, PAGE_MAX, 1'b1);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    wait_drained();

    // Single frame: insert, hit, full, victim, clear, and the hand wrapping.
    write_limit(7'd1);
    queue_req(CMD_ACCESS, PAGE_MAX, 1'b1);
    queue_req(CMD_ACCESS, PAGE_MAX, 1'b0);
    queue_req(CMD_ACCESS, 20'h00000, 1'b1);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    queue_req(CMD_CLEAR, PAGE_MAX, 1'b0);
    queue_req(CMD_CLEAR, 20'h00000, 1'b0);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    wait_drained();

    // Four frames: all use bits set forces the sweep that clears them.
    write_limit(7'd4);
    queue_req(CMD_ACCESS, 20'h00000, 1'b0);
    queue_req(CMD_ACCESS, 20'hAAAAA, 1'b1);
    queue_req(CMD_ACCESS, 20'h55555, 1'b0);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    queue_req(CMD_CLEAR, 20'h00000, 1'b0);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    queue_req(CMD_ACCESS, 20'h00000, 1'b1);
    queue_req(CMD_ACCESS, 20'h0F0F0, 1'b1);
    queue_req(CMD_VICTIM, 20'h00000, 1'b0);
    wait_drained();

    // Small working set; the sender also drains once midway.
    write_limit(7'd16);
    pool_span = 24;
    queue_random(160);
    wait_drained();
    queue_random(170);
    wait_drained();

    // Limit above the table size is capped.
    write_limit(7'd127);
    send_idle_pct = 64;
    recv_idle_pct = 10;
    pool_span = POOL_SIZE;
    queue_random(330);
    wait_drained();

    write_limit(7'd64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(340);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("enhanced_clock_page_replacer_unit verification clean");
    else
      $display("enhanced_clock_page_replacer_unit verification failed");
    $finish;
  end

endmodule
